>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the random walk iterator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion failed");

`endif

>>> src/rwdi_pkg.sv
// ----------------------------------------------------------------------------
// rwdi_pkg
// Shared types and constants of the random walk distribution iterator.
// ----------------------------------------------------------------------------
package rwdi_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = $clog2(MaxVertices + 1);
  localparam logic [31:0] OneQ31      = 32'h8000_0000;

  localparam logic       ReqAddEdge = 1'b0;
  localparam logic       ReqRun     = 1'b1;
  localparam logic [0:0] CfgVertexCount    = 1'b0;
  localparam logic [0:0] CfgIterationCount = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [5:0] src_vertex;
    logic [5:0] dst_vertex;
  } req_t;

  typedef struct packed {
    logic [5:0]  vertex_index;
    logic [31:0] probability;
    logic        last;
  } res_t;

  // floor(2^31 / k) for k in 1..MaxVertices by restoring division, entry 0 unused
  function automatic logic [MaxVertices:0][31:0] recip_table();
    logic [MaxVertices:0][31:0] t;
    logic [32:0] rem;
    t = '0;
    for (int unsigned k = 1; k <= MaxVertices; k++) begin
      rem = '0;
      for (int b = 31; b >= 0; b--) begin
        rem = {rem[31:0], OneQ31[b]};
        if (rem >= 33'(k)) begin
          rem = rem - 33'(k);
          t[k][b] = 1'b1;
        end
      end
    end
    return t;
  endfunction

  localparam logic [MaxVertices:0][31:0] RecipTab = recip_table();

endpackage

>>> src/rwdi_ram.sv
// ----------------------------------------------------------------------------
// rwdi_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module rwdi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> src/random_walk_distribution_iterator_unit.sv
// ----------------------------------------------------------------------------
// random_walk_distribution_iterator_unit
// Adjacency bit matrix plus power iteration of a random walk in Q1.31.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// req     | in        | start && !busy
// cfg     | in        | cfg_valid_i && cfg_ready_o
// res     | out       | res_valid_o, one cycle, no stall
// An edge load reads the row, then writes it back, with busy high throughout.
// After reset a clearing pass zeroes every row of the adjacency RAM.
// A run initialises the vector and accumulator RAMs, then per iteration walks
// the adjacency rows and writes the next vector, then emits the results, paced
// by the adjacency RAM's single read port and the one multiplier.
// Results cannot be stalled; each appears for one cycle.
module random_walk_distribution_iterator_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  rwdi_pkg::req_t        req_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [0:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  output logic                  res_valid_o,
  output rwdi_pkg::res_t        res_o
);
  import rwdi_pkg::*;
`include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EDGE_RD, S_EDGE_WR, S_INIT, S_ROW_RD, S_ROW_WAIT,
    S_MUL, S_SPLIT, S_ACC, S_FIN_RD, S_FIN_WAIT, S_FIN_WR, S_OUT_RD, S_OUT_WAIT
  } state_e;

  state_e state_q;
  logic [6:0]  vcount_q;
  logic [15:0] iters_q, it_q;
  logic [VtxW-1:0] j_q, i_q;
  logic [CntW-1:0] n_eff;
  logic [MaxVertices-1:0] mask, row_q;
  logic [31:0] share_q, spread_q, prev_q;
  logic [63:0] prod_q;
  logic [5:0]  src_q, dst_q;
  logic [CntW-1:0] deg_q;
  logic        bank_q;  // selects which vector RAM holds prev

  always_comb begin
    if (vcount_q == 7'd0) n_eff = CntW'(1);
    else if (vcount_q > 7'(MaxVertices)) n_eff = CntW'(MaxVertices);
    else n_eff = CntW'(vcount_q);
  end
  always_comb begin
    for (int k = 0; k < MaxVertices; k++) mask[k] = (CntW'(k) < n_eff);
  end
  logic [VtxW-1:0] last_idx;
  assign last_idx = VtxW'(n_eff - CntW'(1));

  // adjacency RAM
  logic adj_we;
  logic [VtxW-1:0] adj_wa, adj_ra;
  logic [MaxVertices-1:0] adj_wd, adj_rd;
  rwdi_ram #(.Width(MaxVertices), .Depth(MaxVertices)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(adj_wd),
    .raddr_i(adj_ra), .rdata_o(adj_rd));

  // two vector RAMs for ping-pong; one accumulator RAM
  logic va_we, vb_we, acc_we;
  logic [VtxW-1:0] va_wa, vb_wa, va_ra, vb_ra, acc_wa, acc_ra;
  logic [31:0] va_wd, vb_wd, va_rd, vb_rd;
  logic [38:0] acc_wd, acc_rd;
  rwdi_ram #(.Width(32), .Depth(MaxVertices)) u_va (
    .clk_i, .we_i(va_we), .waddr_i(va_wa), .wdata_i(va_wd),
    .raddr_i(va_ra), .rdata_o(va_rd));
  rwdi_ram #(.Width(32), .Depth(MaxVertices)) u_vb (
    .clk_i, .we_i(vb_we), .waddr_i(vb_wa), .wdata_i(vb_wd),
    .raddr_i(vb_ra), .rdata_o(vb_rd));
  rwdi_ram #(.Width(39), .Depth(MaxVertices)) u_acc (
    .clk_i, .we_i(acc_we), .waddr_i(acc_wa), .wdata_i(acc_wd),
    .raddr_i(acc_ra), .rdata_o(acc_rd));

  logic [31:0] prev_rd;
  assign prev_rd = bank_q ? vb_rd : va_rd;

  logic [CntW-1:0] pop;
  always_comb begin
    pop = '0;
    for (int k = 0; k < MaxVertices; k++) pop = pop + CntW'(adj_rd[k] & mask[k]);
  end

  logic [39:0] sum;
  assign sum = {1'b0, acc_rd} + {8'd0, spread_q};
  logic [31:0] sat;
  assign sat = (sum > {8'd0, OneQ31}) ? OneQ31 : sum[31:0];

  always_comb begin
    adj_we = 1'b0; adj_wa = src_q; adj_wd = adj_rd | (MaxVertices'(1) << dst_q);
    adj_ra = j_q;
    va_we = 1'b0; vb_we = 1'b0; va_wa = i_q; vb_wa = i_q;
    va_wd = '0; vb_wd = '0; va_ra = j_q; vb_ra = j_q;
    acc_we = 1'b0; acc_wa = i_q; acc_ra = i_q; acc_wd = '0;
    case (state_q)
      S_CLEAR: begin adj_we = 1'b1; adj_wa = i_q; adj_wd = '0; end
      S_EDGE_RD: adj_ra = src_q;
      S_EDGE_WR: adj_we = 1'b1;
      S_INIT: begin
        va_we = 1'b1; va_wd = (i_q == '0) ? OneQ31 : '0;
        acc_we = 1'b1;
      end
      S_SPLIT: acc_ra = '0;
      S_ACC: begin
        // fetch the next entry while this one is updated
        acc_ra = i_q + 1'b1;
        acc_we = row_q[i_q] && mask[i_q];
        acc_wd = acc_rd + {7'd0, share_q};
      end
      S_FIN_WR: begin
        acc_we = 1'b1;
        if (bank_q) va_we = 1'b1; else vb_we = 1'b1;
        va_wd = sat; vb_wd = sat;
      end
      S_OUT_RD, S_OUT_WAIT: begin va_ra = i_q; vb_ra = i_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; vcount_q <= 7'(MaxVertices); iters_q <= 16'd999;
      it_q <= '0; j_q <= '0; i_q <= '0; bank_q <= 1'b0; spread_q <= '0;
      res_valid_o <= 1'b0; res_o <= '0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgVertexCount) vcount_q <= cfg_data_i[6:0];
        else vcount_q <= vcount_q;
        if (cfg_index_i == CfgIterationCount) iters_q <= cfg_data_i;
      end
      case (state_q)
        S_CLEAR: begin
          i_q <= i_q + 1'b1;
          if (i_q == VtxW'(MaxVertices - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (start) begin
          src_q <= req_i.src_vertex; dst_q <= req_i.dst_vertex;
          if (req_i.req_type == ReqRun) begin
            i_q <= '0; state_q <= S_INIT;
          end else if ((CntW'(req_i.src_vertex) < n_eff) &&
                       (CntW'(req_i.dst_vertex) < n_eff)) begin
            state_q <= S_EDGE_RD;
          end
        end
        S_EDGE_RD: state_q <= S_EDGE_WR;
        S_EDGE_WR: state_q <= S_IDLE;
        S_INIT: begin
          i_q <= i_q + 1'b1;
          if (i_q == VtxW'(MaxVertices - 1)) begin
            bank_q <= 1'b0; it_q <= '0; j_q <= '0; spread_q <= '0; i_q <= '0;
            state_q <= (iters_q == 16'd0) ? S_OUT_RD : S_ROW_RD;
          end
        end
        S_ROW_RD: state_q <= S_ROW_WAIT;
        S_ROW_WAIT: begin
          row_q <= adj_rd & mask;
          deg_q <= (pop == '0) ? n_eff : pop;
          prev_q <= prev_rd;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q <= 64'(prev_q) * 64'(RecipTab[deg_q]);
          state_q <= S_SPLIT;
        end
        S_SPLIT: begin
          share_q <= prod_q[62:31];
          i_q <= '0;
          if (row_q == '0) begin
            spread_q <= spread_q + prod_q[62:31];
            if (VtxW'(j_q) == last_idx) begin i_q <= '0; state_q <= S_FIN_RD; end
            else begin j_q <= j_q + 1'b1; state_q <= S_ROW_RD; end
          end else state_q <= S_ACC;
        end
        S_ACC: begin
          // acc read for i_q was issued on the previous cycle
          state_q <= S_ACC;
          if (i_q == last_idx) begin
            if (j_q == last_idx) begin i_q <= '0; state_q <= S_FIN_RD; end
            else begin j_q <= j_q + 1'b1; state_q <= S_ROW_RD; end
          end else i_q <= i_q + 1'b1;
        end
        S_FIN_RD: state_q <= S_FIN_WAIT;
        S_FIN_WAIT: state_q <= S_FIN_WR;
        S_FIN_WR: begin
          if (i_q == last_idx) begin
            bank_q <= ~bank_q; spread_q <= '0; j_q <= '0; i_q <= '0;
            if (it_q + 16'd1 == iters_q) state_q <= S_OUT_RD;
            else begin it_q <= it_q + 16'd1; state_q <= S_ROW_RD; end
          end else begin i_q <= i_q + 1'b1; state_q <= S_FIN_RD; end
        end
        S_OUT_RD: state_q <= S_OUT_WAIT;
        S_OUT_WAIT: begin
          res_valid_o <= 1'b1;
          res_o.vertex_index <= 6'(i_q);
          res_o.probability <= prev_rd;
          res_o.last <= (i_q == last_idx);
          if (i_q == last_idx) state_q <= S_IDLE;
          else begin i_q <= i_q + 1'b1; state_q <= S_OUT_RD; end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  `ASSERT_IMPL(a_res_only_out, clk_i, rst_ni, res_valid_o, $past(state_q) == S_OUT_WAIT)
  `ASSERT_IMPL(a_last_idle, clk_i, rst_ni, res_valid_o && res_o.last, state_q == S_IDLE)
  `ASSERT_NEVER(a_prob_range, clk_i, rst_ni, res_valid_o && res_o.probability > OneQ31)
endmodule

>>> dv/rwdi_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwdi_result_checker
// Watches the request, register and result channels of the random walk
// iterator, keeps its own adjacency matrix and register copies, computes the
// expected Q1.31 distribution of every run and compares each result with it.
// ----------------------------------------------------------------------------
module rwdi_result_checker
  import rwdi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  req_t        req_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        res_valid_o,
  input  res_t        res_o,
  output int          outstanding_o,
  output int          error_count_o
);

  logic [63:0] graph_rows [64];
  logic [6:0]  vertex_count_q;
  logic [15:0] iteration_count_q;
  res_t        expected_probs [$];
  int          error_count;

  assign outstanding_o = expected_probs.size();
  assign error_count_o = error_count;

  task automatic report(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned live_vertices();
    int unsigned n;
    n = vertex_count_q;
    if (n == 0) n = 1;
    if (n > MaxVertices) n = MaxVertices;
    return n;
  endfunction

  // truncated prev / k in Q1.31
  function automatic logic [31:0] split_share(input logic [31:0] p, input int unsigned k);
    longint unsigned r;
    longint unsigned prod;
    r    = 64'h8000_0000 / k;
    prod = longint'(p) * r;
    return prod[62:31];
  endfunction

  task automatic predict_walk();
    int unsigned     n;
    int unsigned     deg;
    logic [63:0]     mask;
    logic [63:0]     row;
    logic [31:0]     prev [64];
    logic [31:0]     cur [64];
    longint unsigned acc [64];
    longint unsigned spread;
    longint unsigned s;
    logic [31:0]     c;
    res_t            r;
    n    = live_vertices();
    mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    for (int i = 0; i < 64; i++) prev[i] = '0;
    prev[0] = OneQ31;
    cur = prev;
    for (int it = 0; it < int'(iteration_count_q); it++) begin
      spread = 0;
      for (int i = 0; i < 64; i++) acc[i] = 0;
      for (int j = 0; j < int'(n); j++) begin
        row = graph_rows[j] & mask;
        deg = $countones(row);
        if (deg == 0) begin
          spread += split_share(prev[j], n);
        end else begin
          c = split_share(prev[j], deg);
          for (int i = 0; i < int'(n); i++) if (row[i]) acc[i] += c;
        end
      end
      for (int i = 0; i < int'(n); i++) begin
        s = acc[i] + spread;
        cur[i] = (s > 64'h8000_0000) ? OneQ31 : s[31:0];
      end
      prev = cur;
    end
    for (int i = 0; i < int'(n); i++) begin
      r.vertex_index = 6'(i);
      r.probability  = cur[i];
      r.last         = (i + 1 == int'(n));
      expected_probs.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    int unsigned n;
    if (!rst_ni) begin
      for (int i = 0; i < 64; i++) graph_rows[i] <= '0;
      vertex_count_q    <= 7'd64;
      iteration_count_q <= 16'd999;
      expected_probs.delete();
      error_count = 0;
    end else begin
      if (res_valid_o) begin
        if (expected_probs.size() == 0) begin
          report($sformatf("unexpected result vertex %0d", res_o.vertex_index));
        end else begin
          exp_r = expected_probs.pop_front();
          if (res_o.vertex_index !== exp_r.vertex_index)
            report($sformatf("vertex_index got %0d exp %0d",
                             res_o.vertex_index, exp_r.vertex_index));
          if (res_o.probability !== exp_r.probability)
            report($sformatf("vertex %0d probability got %h exp %h",
                             exp_r.vertex_index, res_o.probability, exp_r.probability));
          if (res_o.last !== exp_r.last)
            report($sformatf("vertex %0d last got %b exp %b",
                             exp_r.vertex_index, res_o.last, exp_r.last));
        end
      end
      if (start && !busy) begin
        n = live_vertices();
        if (req_i.req_type == ReqRun) begin
          predict_walk();
        end else if (req_i.src_vertex < n && req_i.dst_vertex < n) begin
          graph_rows[req_i.src_vertex][req_i.dst_vertex] <= 1'b1;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgVertexCount) vertex_count_q <= cfg_data_i[6:0];
        else iteration_count_q <= cfg_data_i;
      end
    end
  end

endmodule

>>> dv/tb_random_walk_distribution_iterator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_walk_distribution_iterator_unit
// Drives edge loads, runs and register writes into the iterator with random
// gaps; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_random_walk_distribution_iterator_unit;
  import rwdi_pkg::*;

  localparam int MaxCycles = 12_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = CfgVertexCount;
  logic [15:0] cfg_data_i = '0;
  logic        res_valid_o;
  res_t        res_o;
  int          outstanding;
  int          error_count;
  int          cycle_count = 0;
  int unsigned live_n = 64;
  int          walk_items = 0;
  bit          no_idle = 1'b0;

  random_walk_distribution_iterator_unit u_dut (.*);

  rwdi_result_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .req_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .res_valid_o, .res_o,
    .outstanding_o(outstanding), .error_count_o(error_count)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_req(input logic kind, input int src, input int dst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{req_type: kind, src_vertex: 6'(src), dst_vertex: 6'(dst)};
    do @(posedge clk_i); while (busy);
    walk_items++;
  endtask

  // hold until every expected result is in and the block is quiet
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgVertexCount) begin
      live_n = data[6:0];
      if (live_n == 0) live_n = 1;
      if (live_n > 64) live_n = 64;
    end
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned vc;
    int unsigned iters;
    int unsigned span;
    int          len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero iterations, duplicate edge, out-of-range edge, dangling vertex
    write_reg(CfgVertexCount, 16'd4);
    write_reg(CfgIterationCount, 16'd0);
    send_req(ReqAddEdge, 63, 63);
    send_req(ReqAddEdge, 0, 1);
    send_req(ReqAddEdge, 0, 1);
    send_req(ReqAddEdge, 1, 2);
    send_req(ReqAddEdge, 2, 0);
    send_req(ReqAddEdge, 0, 5);
    send_req(ReqRun, 0, 0);
    write_reg(CfgIterationCount, 16'd3);
    send_req(ReqRun, 63, 63);
    // count of zero acts as one, longest iteration count
    write_reg(CfgVertexCount, 16'hFF80);
    write_reg(CfgIterationCount, 16'hFFFF);
    send_req(ReqRun, 0, 0);
    // count above the maximum acts as the maximum
    write_reg(CfgVertexCount, 16'd127);
    write_reg(CfgIterationCount, 16'd1);
    send_req(ReqAddEdge, 63, 0);
    send_req(ReqAddEdge, 0, 63);
    send_req(ReqAddEdge, 42, 21);
    send_req(ReqRun, 0, 0);
    // shrink after loading
    write_reg(CfgVertexCount, 16'd2);
    write_reg(CfgIterationCount, 16'd5);
    send_req(ReqRun, 0, 0);
    write_reg(CfgVertexCount, 16'd1);
    send_req(ReqRun, 0, 0);

    while (walk_items < 480) begin
      case ($urandom_range(0, 9))
        0:       vc = $urandom_range(0, 1);
        1:       vc = $urandom_range(9, 20);
        2:       vc = ($urandom_range(0, 1) != 0) ? 64 : $urandom_range(65, 127);
        default: vc = $urandom_range(2, 8);
      endcase
      iters = (vc >= 21) ? $urandom_range(0, 2) :
              ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 20);
      write_reg(CfgVertexCount, {7'($urandom), 2'($urandom), 7'(vc)});
      write_reg(CfgIterationCount, 16'(iters));
      no_idle = ($urandom_range(0, 3) == 0);
      len = $urandom_range(10, 40);
      span = live_n + 1;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 7) == 0) send_req(ReqRun, $urandom_range(0, 63),
                                                $urandom_range(0, 63));
        else if ($urandom_range(0, 9) == 0) send_req(ReqAddEdge, $urandom_range(0, 63),
                                                     $urandom_range(0, 63));
        else send_req(ReqAddEdge, $urandom_range(0, span - 1), $urandom_range(0, span - 1));
      end
      send_req(ReqRun, 0, 0);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/rwdi_pkg.sv
src/rwdi_ram.sv
src/random_walk_distribution_iterator_unit.sv
dv/rwdi_result_checker.sv
dv/tb_random_walk_distribution_iterator_unit.sv
